FILE: sv/bqf_pkg.sv
package bqf_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CoefWidth     = 32;
    localparam int SampleWidth   = 24;
    localparam int DelayWidth    = 48;
    localparam int ProdWidth     = 64;

    localparam logic [CfgIndexWidth-1:0] CFG_FEED_ZERO = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_FEED_ONE  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_FEED_TWO  = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_BACK_ONE  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_BACK_TWO  = 3'd4;

    localparam logic signed [CoefWidth-1:0] RST_FEED_ZERO = 32'sd536870912;

    localparam logic signed [ProdWidth-1:0] MAX24 = 64'sd8388607;
    localparam logic signed [ProdWidth-1:0] MIN24 = -64'sd8388608;
    localparam logic signed [ProdWidth-1:0] MAX32 = 64'sd2147483647;
    localparam logic signed [ProdWidth-1:0] MIN32 = -64'sd2147483648;
    localparam logic signed [ProdWidth-1:0] MAX48 = 64'sd140737488355327;
    localparam logic signed [ProdWidth-1:0] MIN48 = -64'sd140737488355328;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_Y,
        S_N1A,
        S_N1B,
        S_N2A,
        S_N2B,
        S_DONE
    } t_state;

    // round half up to 23 fraction bits, saturate to 24 bits; msb is the clip flag
    function automatic logic [SampleWidth:0] f_round_out(input logic signed [ProdWidth-1:0] v);
        logic signed [ProdWidth-1:0] t;
        logic [SampleWidth:0] r;
        t = (v + (64'sd1 <<< 28)) >>> 29;
        if (t > MAX24) begin
            r = {1'b1, MAX24[SampleWidth-1:0]};
        end else if (t < MIN24) begin
            r = {1'b1, MIN24[SampleWidth-1:0]};
        end else begin
            r = {1'b0, t[SampleWidth-1:0]};
        end
        return r;
    endfunction

    // feedback value, Q1.31
    function automatic logic signed [CoefWidth-1:0] f_round_fb(
        input logic signed [ProdWidth-1:0] v);
        logic signed [ProdWidth-1:0] t;
        logic signed [CoefWidth-1:0] r;
        t = (v + (64'sd1 <<< 20)) >>> 21;
        if (t > MAX32) begin
            r = MAX32[CoefWidth-1:0];
        end else if (t < MIN32) begin
            r = MIN32[CoefWidth-1:0];
        end else begin
            r = t[CoefWidth-1:0];
        end
        return r;
    endfunction

    // delay update, 47 fraction bits
    function automatic logic signed [DelayWidth-1:0] f_round_delay(
        input logic signed [ProdWidth-1:0] v);
        logic signed [ProdWidth-1:0] t;
        logic signed [DelayWidth-1:0] r;
        t = (v + 64'sd16) >>> 5;
        if (t > MAX48) begin
            r = MAX48[DelayWidth-1:0];
        end else if (t < MIN48) begin
            r = MIN48[DelayWidth-1:0];
        end else begin
            r = t[DelayWidth-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/bqf_ram.sv
module bqf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/biquad_filter_per_channel_unit.sv
// channel   | direction | tdata                  | tuser
// s_axis    | in        | [23:0] sample_in       | [0] channel_in
// m_axis    | out       | [23:0] sample_out      | [0] channel_out, [1] clipped
// cfg write | in        | i_cfg_data coefficient | i_cfg_index register
//
// each beat takes one state read from the delay ram, five passes
// through the single 32x32 multiplier and one write back of both delays
// one beat is in flight at a time; a finished result waits in the output register
// while the next beat is accepted; a stalled output holds the write back
// synchronous active-low reset clears coefficients to defaults and the delay valid
// bits, so every channel starts from zero state with no clearing pass
module biquad_filter_per_channel_unit
    import bqf_pkg::*;
#(
    parameter int CHANNELS = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [23:0]              s_axis_tdata,  // [23:0] sample_in
    input  logic                     s_axis_tuser,  // [0] channel_in
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [23:0]              m_axis_tdata,  // [23:0] sample_out
    output logic [1:0]               m_axis_tuser,  // [0] channel_out, [1] clipped
    input  logic                     i_cfg_we,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CoefWidth-1:0]     i_cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RamWidth = 2 * DelayWidth;

    t_state r_state, n_state;

    logic signed [CoefWidth-1:0] r_a0, r_a1, r_a2, r_b1, r_b2;
    logic [CHANNELS-1:0]         r_valid;

    logic signed [SampleWidth-1:0] r_x;
    logic                          r_chan;
    logic [AW-1:0]                 r_addr;
    logic signed [DelayWidth-1:0]  r_z1, r_z2, r_z1n, r_z2n;
    logic signed [ProdWidth-1:0]   r_prod, r_acc;
    logic signed [CoefWidth-1:0]   r_yfb;
    logic [SampleWidth-1:0]        r_yout;
    logic                          r_clip;

    logic                          r_out_valid;
    logic [SampleWidth-1:0]        r_out_data;
    logic [1:0]                    r_out_user;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_ram_we;
    logic [AW-1:0]                 w_in_addr;
    logic [RamWidth-1:0]           w_rdata;
    logic signed [DelayWidth-1:0]  w_rd_z1, w_rd_z2;
    logic signed [CoefWidth-1:0]   w_ma, w_mb;
    logic signed [SampleWidth-1:0] w_x;
    logic signed [ProdWidth-1:0]   w_y, w_n;
    logic [SampleWidth:0]          w_out;

    assign w_x        = s_axis_tdata;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_in_addr  = (CHANNELS > 1) ? AW'(s_axis_tuser) : '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_READ;
            S_READ: n_state = S_Y;
            S_Y:    n_state = S_N1A;
            S_N1A:  n_state = S_N1B;
            S_N1B:  n_state = S_N2A;
            S_N2A:  n_state = S_N2B;
            S_N2B:  n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_ram_we      = 1'b0;
        w_ma          = r_a0;
        w_mb          = CoefWidth'(r_x);
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_READ: begin
                w_ma = r_a0;
                w_mb = CoefWidth'(r_x);
            end
            S_Y: begin
                w_ma = r_a1;
                w_mb = CoefWidth'(r_x);
            end
            S_N1A: begin
                w_ma = r_b1;
                w_mb = r_yfb;
            end
            S_N1B: begin
                w_ma = r_a2;
                w_mb = CoefWidth'(r_x);
            end
            S_N2A: begin
                w_ma = r_b2;
                w_mb = r_yfb;
            end
            S_DONE: w_ram_we = w_out_free;
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0 <= RST_FEED_ZERO;
            r_a1 <= '0;
            r_a2 <= '0;
            r_b1 <= '0;
            r_b2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FEED_ZERO: r_a0 <= i_cfg_data;
                CFG_FEED_ONE:  r_a1 <= i_cfg_data;
                CFG_FEED_TWO:  r_a2 <= i_cfg_data;
                CFG_BACK_ONE:  r_b1 <= i_cfg_data;
                CFG_BACK_TWO:  r_b2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_ram_we) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    bqf_ram #(
        .WIDTH(RamWidth),
        .DEPTH(CHANNELS)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_addr),
        .i_wdata ({r_z1n, r_z2n}),
        .i_re    (w_accept),
        .i_raddr (w_in_addr),
        .o_rdata (w_rdata)
    );

    // unwritten channels read as zero
    assign w_rd_z1 = r_valid[r_addr] ? w_rdata[RamWidth-1:DelayWidth] : '0;
    assign w_rd_z2 = r_valid[r_addr] ? w_rdata[DelayWidth-1:0] : '0;

    assign w_y   = r_prod + {{(ProdWidth-DelayWidth-5){r_z1[DelayWidth-1]}}, r_z1, 5'b0};
    assign w_out = f_round_out(w_y);
    assign w_n   = r_acc - (r_prod >>> 8);

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (w_accept) begin
            r_x    <= w_x;
            r_chan <= s_axis_tuser;
            r_addr <= w_in_addr;
        end
        case (r_state)
            S_READ: begin
                r_z1 <= w_rd_z1;
                r_z2 <= w_rd_z2;
            end
            S_Y: begin
                r_yout <= w_out[SampleWidth-1:0];
                r_clip <= w_out[SampleWidth];
                r_yfb  <= f_round_fb(w_y);
            end
            S_N1A: r_acc <= r_prod
                + {{(ProdWidth-DelayWidth-5){r_z2[DelayWidth-1]}}, r_z2, 5'b0};
            S_N1B: r_z1n <= f_round_delay(w_n);
            S_N2A: r_acc <= r_prod;
            S_N2B: r_z2n <= f_round_delay(w_n);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ram_we) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ram_we) begin
            r_out_data <= r_yout;
            r_out_user <= {r_clip, r_chan};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

FILE: sv/bqf_checker.sv
module bqf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output beat changed under stall");

    // one beat in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a beat is in flight");

    // a new result appears only as the block returns to accepting input
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(!s_axis_tready) && s_axis_tready))
        else $error("result appeared outside end of work");

    // clip flag only with a full-scale sample
    a_clip_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1])
            |-> (m_axis_tdata == 24'h7FFFFF || m_axis_tdata == 24'h800000))
        else $error("clip flag without saturated sample");

    // reset empties the output and reopens the input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("reset did not clear handshake state");

endmodule

bind biquad_filter_per_channel_unit bqf_checker u_bqf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
